// ===== design/visibility_rle_decoder_defines.svh =====
// assertion macros shared by the visibility decoder checker
// no dependencies; clk and rst_n must be visible where the macros are used
`ifndef VISIBILITY_RLE_DECODER_DEFINES_SVH
`define VISIBILITY_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vrd_pkg.sv =====
// shared types and constants for the visibility row decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vrd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CTR_W    = 14;
    localparam int CTR_MAX  = 16383;
    localparam int BIT_W    = $clog2(BYTE_W);

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // work for the back part: a zero mask means one empty status result
    typedef struct packed {
        logic [BYTE_W-1:0] mask;
        logic [CTR_W-1:0]  base;
        logic              done;
    } vrd_cmd_t;

endpackage

`default_nettype wire

// ===== design/vrd_queue.sv =====
// short command queue between the front and back parts
// depends on vrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrd_queue
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    wr_en,
    input  wire vrd_pkg::vrd_cmd_t wr_cmd,
    output logic                   q_full,
    input  wire                    rd_en,
    output vrd_pkg::vrd_cmd_t      rd_cmd,
    output logic                   rd_valid
);
    import vrd_pkg::*;

    vrd_cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]     count_reg, count_next;

    assign q_full   = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/vrd_front.sv =====
// front part: leaf counter, count-byte tracking and classification of each byte
// depends on vrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrd_front
#(
    parameter int unsigned MAX_LEAVES = 8192
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  wire  [vrd_pkg::BYTE_W-1:0]   data_byte,
    input  wire                          row_start,
    input  wire                          q_full,
    input  wire                          cfg_wr,
    input  wire  [vrd_pkg::CTR_W-1:0]    cfg_data,
    output logic                         cmd_wr,
    output vrd_pkg::vrd_cmd_t            cmd
);
    import vrd_pkg::*;

    localparam int unsigned MAX_CAP =
        (MAX_LEAVES > CTR_MAX) ? CTR_MAX : MAX_LEAVES;

    logic [CTR_W-1:0] ctr_reg, ctr_next;
    logic             exp_reg, exp_next;
    logic [CTR_W-1:0] vlc_reg;

    logic [CTR_W-1:0] ctr_in;
    logic             exp_in;
    logic [CTR_W-1:0] lim;
    logic [CTR_W:0]   step_sum;
    logic [CTR_W-1:0] step_sat;

    assign cmd_wr = push && !q_full;
    assign lim    = (vlc_reg > CTR_W'(MAX_CAP)) ? CTR_W'(MAX_CAP) : vlc_reg;
    assign ctr_in = row_start ? CTR_W'(1) : ctr_reg;
    assign exp_in = row_start ? 1'b0 : exp_reg;

    always_comb
    begin
        // a count byte skips byte*8 leaves, a literal byte always 8
        if (exp_in)
        begin
            step_sum = {1'b0, ctr_in} + {(CTR_W - BYTE_W - 2)'(0), data_byte, 3'b000};
        end
        else
        begin
            step_sum = {1'b0, ctr_in} + (CTR_W + 1)'(BYTE_W);
        end
        step_sat = step_sum[CTR_W] ? CTR_W'(CTR_MAX) : step_sum[CTR_W-1:0];
    end

    always_comb
    begin
        ctr_next  = ctr_in;
        exp_next  = exp_in;
        cmd.mask  = '0;
        cmd.base  = ctr_in;
        if (exp_in)
        begin
            exp_next = 1'b0;
            ctr_next = step_sat;
        end
        else if (ctr_in < lim)
        begin
            if (data_byte == '0)
            begin
                exp_next = 1'b1;
            end
            else
            begin
                ctr_next = step_sat;
                cmd.mask = data_byte;
            end
        end
        cmd.done = (ctr_next >= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= CTR_W'(1);
            exp_reg <= 1'b0;
            vlc_reg <= '0;
        end
        else
        begin
            if (cmd_wr)
            begin
                ctr_reg <= ctr_next;
                exp_reg <= exp_next;
            end
            if (cfg_wr)
            begin
                vlc_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/vrd_back.sv =====
// back part: expands each command into results, one set bit per beat, or one empty status result for a zero mask
// depends on vrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrd_back
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          q_valid,
    input  wire vrd_pkg::vrd_cmd_t       q_head,
    output logic                         q_pop,
    input  wire                          pop,
    output logic                         empty,
    output logic                         has_leaf,
    output logic [vrd_pkg::CTR_W-1:0]    leaf_number,
    output logic                         last,
    output logic                         row_done
);
    import vrd_pkg::*;

    logic              busy_reg, busy_next;
    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic              has_reg;
    logic [CTR_W-1:0]  leaf_reg;
    logic              last_reg;
    logic              done_reg;

    logic [BYTE_W-1:0] cur_mask;
    logic [BYTE_W-1:0] rest;
    logic [BIT_W-1:0]  idx;
    logic              is_last;
    logic              load;

    assign empty       = !out_valid_reg;
    assign has_leaf    = has_reg;
    assign leaf_number = leaf_reg;
    assign last        = last_reg;
    assign row_done    = done_reg;

    // bits already sent for the head command are cleared in rem_reg
    assign cur_mask = busy_reg ? rem_reg : q_head.mask;
    assign rest     = cur_mask & (cur_mask - 1'b1);
    assign is_last  = (rest == '0);
    assign load     = q_valid && (!out_valid_reg || pop);
    assign q_pop    = load && is_last;

    always_comb
    begin
        idx = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (cur_mask[i])
            begin
                idx = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            busy_next      = !is_last;
            rem_next       = rest;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (load)
        begin
            has_reg  <= (cur_mask != '0);
            leaf_reg <= (cur_mask != '0) ? q_head.base + CTR_W'(idx) : '0;
            last_reg <= is_last;
            done_reg <= q_head.done;
        end
    end

endmodule

`default_nettype wire

// ===== design/visibility_rle_decoder.sv =====
// top level of the run-length visibility row decoder
// depends on vrd_pkg, vrd_front, vrd_queue, vrd_back
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | push / full               | data_byte, row_start
//  result   | pop / empty               | has_leaf, leaf_number, last, row_done
//  config   | cfg_valid / cfg_ready     | cfg_data (visible leaf count)
//
//  a byte is taken every cycle while the 4-entry command queue has room
//  results leave one per cycle while pop is high: a decoded literal byte with k set bits
//  gives k results, any other byte one result, so the result port sets the sustained rate
//  reset: leaf counter 1, leaf count register 0, queue and result stage empty
//  cfg_ready stays high; the result stage refills in the same cycle it is popped if the queue holds a command
`timescale 1ns / 1ps
`default_nettype none

module visibility_rle_decoder
#(
    parameter int unsigned MAX_LEAVES = 8192
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire  [vrd_pkg::BYTE_W-1:0]   data_byte,
    input  wire                          row_start,
    output logic                         empty,
    input  wire                          pop,
    output logic                         has_leaf,
    output logic [vrd_pkg::CTR_W-1:0]    leaf_number,
    output logic                         last,
    output logic                         row_done,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [vrd_pkg::CTR_W-1:0]    cfg_data
);
    import vrd_pkg::*;

    logic     cmd_wr;
    vrd_cmd_t cmd;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    vrd_cmd_t q_head;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    vrd_front #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .row_start (row_start),
        .q_full    (q_full),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_wr    (cmd_wr),
        .cmd       (cmd)
    );

    vrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_wr),
        .wr_cmd   (cmd),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_cmd   (q_head),
        .rd_valid (q_valid)
    );

    vrd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .has_leaf    (has_leaf),
        .leaf_number (leaf_number),
        .last        (last),
        .row_done    (row_done)
    );

endmodule

`default_nettype wire

// ===== design/vrd_checker.sv =====
// port-level checks for the visibility row decoder, bound to the top level
// depends on visibility_rle_decoder_defines.svh and visibility_rle_decoder
`timescale 1ns / 1ps
`default_nettype none

module vrd_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        pop,
    input wire        empty,
    input wire        has_leaf,
    input wire [13:0] leaf_number,
    input wire        last,
    input wire        row_done
);
`include "visibility_rle_decoder_defines.svh"

    // an empty status result stands alone for its byte and carries no leaf
    `VRD_ASSERT_NOW(a_empty_status_shape, !empty && !has_leaf, last && (leaf_number == 14'd0), "empty status result malformed")

    // the rest of a literal byte follows in the very next beat, same row state
    `VRD_ASSERT_NEXT(a_leaf_burst_continues, !empty && pop && has_leaf && !last, !empty && has_leaf && (row_done == $past(row_done)), "leaf burst broken")

    // a waiting beat does not change or vanish
    `VRD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(leaf_number) && $stable(has_leaf) && $stable(last), "waiting result changed")

endmodule

bind visibility_rle_decoder vrd_checker u_vrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .has_leaf    (has_leaf),
    .leaf_number (leaf_number),
    .last        (last),
    .row_done    (row_done)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for visibility_rle_decoder: a directed table, then random rows
// depends on vrd_pkg and the visibility_rle_decoder rtl; no other files
`timescale 1ns / 1ps

module tb_top;

    import vrd_pkg::*;

    localparam int LEAF_CAP     = 8192;     // MAX_LEAVES of the instance
    localparam int QUIET_LIMIT  = 4000;     // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 80;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 75;

    typedef struct packed {
        logic             has;
        logic [CTR_W-1:0] leaf;
        logic             last;
        logic             done;
    } leaf_beat_t;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [CTR_W-1:0] val;
        bit         rs;
        bit         typed;
        leaf_beat_t exp;
    } dir_row_t;

    localparam leaf_beat_t EMPTY_DONE = '{1'b0, 14'd0, 1'b1, 1'b1};
    localparam leaf_beat_t EMPTY_OPEN = '{1'b0, 14'd0, 1'b1, 1'b0};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [BYTE_W-1:0] data_byte = '0;
    logic             row_start = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic             has_leaf;
    logic [CTR_W-1:0] leaf_number;
    logic             last;
    logic             row_done;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CTR_W-1:0] cfg_data = '0;

    // typed expectation that travels with the beat it belongs to
    bit               pin_on = 1'b0;
    leaf_beat_t       pin_beat = '0;

    // decoder copy kept by the bench
    int unsigned      leaf_ctr = 1;
    bit               cnt_pending = 1'b0;
    logic [CTR_W-1:0] leaf_cnt_reg = '0;
    leaf_beat_t       pred_beats [8];
    leaf_beat_t       leaf_q [$];

    dir_row_t         dir_tab [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_go = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int quiet = 0;

    int n_fail = 0;
    int n_bytes = 0;
    int n_useful = 0;
    int n_results = 0;
    int n_leaves = 0;
    int n_done = 0;
    int n_cfg = 0;

    visibility_rle_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .row_start   (row_start),
        .empty       (empty),
        .pop         (pop),
        .has_leaf    (has_leaf),
        .leaf_number (leaf_number),
        .last        (last),
        .row_done    (row_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%s", msg);
    endfunction

    // appends one expected beat to the tail of the result store
    function automatic void expect_beat(input leaf_beat_t bt);
        leaf_q.insert(leaf_q.size(), bt);
    endfunction

    // decodes one byte into pred_beats, returns the beat count
    function automatic int decode_byte(input logic [BYTE_W-1:0] b, input bit rs,
                                       output bit skipped);
        int unsigned lim;
        int unsigned base;
        int unsigned sum;
        bit          done;
        int          n;
        skipped = 1'b0;
        if (rs)
        begin
            leaf_ctr = 1;
            cnt_pending = 1'b0;
        end
        lim = (leaf_cnt_reg > LEAF_CAP) ? LEAF_CAP : leaf_cnt_reg;
        if (cnt_pending)
        begin
            cnt_pending = 1'b0;
            sum = leaf_ctr + (int'(b) << 3);
            leaf_ctr = (sum > CTR_MAX) ? CTR_MAX : sum;
        end
        else if (leaf_ctr < lim)
        begin
            if (b == 0)
                cnt_pending = 1'b1;
            else
            begin
                base = leaf_ctr;
                sum = leaf_ctr + 8;
                leaf_ctr = (sum > CTR_MAX) ? CTR_MAX : sum;
                done = (leaf_ctr >= lim);
                n = 0;
                for (int i = 0; i < BYTE_W; i++)
                begin
                    if (b[i])
                    begin
                        pred_beats[n] = '{1'b1, CTR_W'(base + i), 1'b0, done};
                        n++;
                    end
                end
                pred_beats[n-1].last = 1'b1;
                return n;
            end
        end
        else
            skipped = 1'b1;
        pred_beats[0] = '{1'b0, '0, 1'b1, leaf_ctr >= lim};
        return 1;
    endfunction

    // beat monitor: checks results, predicts accepted bytes, tracks the register
    always @(posedge clk)
    begin
        leaf_beat_t got;
        leaf_beat_t want;
        int         n;
        bit         skipped;
        if (rst_n)
        begin
            if (pop === 1'b1 && empty === 1'b0)
            begin
                got = '{has_leaf, leaf_number, last, row_done};
                n_results++;
                if (has_leaf === 1'b1)
                    n_leaves++;
                if (row_done === 1'b1)
                    n_done++;
                if (leaf_q.size() == 0)
                    note_fail($sformatf("unexpected result has=%0d leaf=%0d last=%0d done=%0d",
                                        has_leaf, leaf_number, last, row_done));
                else
                begin
                    want = leaf_q.pop_front();
                    if (got !== want)
                        note_fail($sformatf({"mismatch: exp has=%0d leaf=%0d last=%0d done=%0d",
                                             " got has=%0d leaf=%0d last=%0d done=%0d"},
                                            want.has, want.leaf, want.last, want.done,
                                            got.has, got.leaf, got.last, got.done));
                end
            end
            if (push && full === 1'b0)
            begin
                n = decode_byte(data_byte, row_start, skipped);
                n_bytes++;
                if (!skipped)
                    n_useful++;
                if (pin_on)
                    expect_beat(pin_beat);
                else
                    for (int i = 0; i < n; i++)
                        expect_beat(pred_beats[i]);
            end
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                leaf_cnt_reg = cfg_data;
                n_cfg++;
            end
        end
    end

    // watchdog on channel activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && full === 1'b0) || (pop && empty === 1'b0) ||
                (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         quiet, leaf_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random stalls plus one long hold so the input backs up
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (hold_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit rs,
                             input bit pinned, input leaf_beat_t pb);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        row_start <= rs;
        pin_on <= pinned;
        pin_beat <= pb;
        do
            @(posedge clk);
        while (full !== 1'b0);
    endtask

    // every byte gives at least one result, so an empty store means idle
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (leaf_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_leaf_count(input logic [CTR_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_rand(input logic [BYTE_W-1:0] b, input bit rs);
        send_byte(b, rs, 1'b0, '0);
    endtask

    function automatic void add_row(input row_kind_t kind, input int unsigned val,
                                    input bit rs, input bit typed, input leaf_beat_t exp);
        dir_tab.insert(dir_tab.size(), '{kind, CTR_W'(val), rs, typed, exp});
    endfunction

    initial
    begin
        int unsigned phase_lim [NUM_PHASES];
        int          goal;
        int          len;
        int          sel;
        bit          first;
        logic [BYTE_W-1:0] b;

        // reset leaves the leaf count at zero: every row is over at its start
        add_row(ROW_BYTE, 'hFF, 1'b1, 1'b1, EMPTY_DONE);
        add_row(ROW_BYTE, 'h00, 1'b0, 1'b1, EMPTY_DONE);
        add_row(ROW_CFG, 8192, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, 'h01, 1'b1, 1'b1, '{1'b1, 14'd1, 1'b1, 1'b0});
        add_row(ROW_BYTE, 'h80, 1'b0, 1'b1, '{1'b1, 14'd16, 1'b1, 1'b0});
        add_row(ROW_BYTE, 'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, 'h00, 1'b0, 1'b1, EMPTY_OPEN);
        add_row(ROW_BYTE, 'hFF, 1'b0, 1'b1, EMPTY_OPEN);    // largest skip
        add_row(ROW_BYTE, 'h00, 1'b0, 1'b1, EMPTY_OPEN);
        add_row(ROW_BYTE, 'h00, 1'b0, 1'b1, EMPTY_OPEN);    // zero skip still eats the byte
        add_row(ROW_BYTE, 'hAA, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, 'h00, 1'b1, 1'b1, EMPTY_OPEN);
        add_row(ROW_BYTE, 'h00, 1'b1, 1'b1, EMPTY_OPEN);    // row start drops the pending skip
        add_row(ROW_BYTE, 'h55, 1'b1, 1'b0, '0);
        add_row(ROW_CFG, 1, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, 'hFF, 1'b1, 1'b1, EMPTY_DONE);
        add_row(ROW_CFG, 20, 1'b0, 1'b0, '0);
        add_row(ROW_BYTE, 'h01, 1'b1, 1'b1, '{1'b1, 14'd1, 1'b1, 1'b0});
        add_row(ROW_BYTE, 'h01, 1'b0, 1'b1, '{1'b1, 14'd9, 1'b1, 1'b0});
        add_row(ROW_BYTE, 'h81, 1'b0, 1'b0, '0);            // decodes past the limit
        add_row(ROW_BYTE, 'hFF, 1'b0, 1'b1, EMPTY_DONE);
        add_row(ROW_BYTE, 'h00, 1'b0, 1'b1, EMPTY_DONE);
        add_row(ROW_BYTE, 'h00, 1'b1, 1'b1, EMPTY_OPEN);
        add_row(ROW_BYTE, 'h03, 1'b0, 1'b1, EMPTY_DONE);
        add_row(ROW_BYTE, 'h02, 1'b0, 1'b1, EMPTY_DONE);

        phase_lim = '{96, 8192, 40, 8191, 24, $urandom_range(2, 400)};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_leaf_count(dir_tab[i].val);
            else
                send_byte(dir_tab[i].val[BYTE_W-1:0], dir_tab[i].rs,
                          dir_tab[i].typed, dir_tab[i].exp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_leaf_count(CTR_W'(phase_lim[p]));
            tx_idle_pct = (p < 2) ? 37 : (p < 4) ? 85 : 0;
            rx_idle_pct = (p < 2) ? 85 : (p < 4) ? 37 : 0;
            if (p == 0)
                hold_go = 1'b1;
            goal = n_bytes + PHASE_ITEMS;
            while (n_bytes < goal)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // well-formed row with random content
                    len = $urandom_range(1, 20);
                    first = 1'b1;
                    repeat (len)
                    begin
                        sel = $urandom_range(99);
                        if (sel < 10)
                            b = 8'h01 << $urandom_range(7);
                        else if (sel < 60)
                            b = BYTE_W'($urandom_range(1, 255));
                        else if (sel < 90)
                            b = 8'h00;
                        else
                            b = 8'hFF;
                        send_rand(b, first);
                        first = 1'b0;
                        if (b == 0 && sel < 85)
                            send_rand(($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255))
                                                              : BYTE_W'($urandom_range(3)),
                                      1'b0);
                    end
                end
                else
                    send_rand(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (leaf_q.size() != 0)
            note_fail($sformatf("%0d expected results never arrived", leaf_q.size()));

        $display("covered %0d bytes (%0d decoded), %0d register writes, %0d results",
                 n_bytes, n_useful, n_cfg, n_results);
        $display("%0d visible leaves, %0d results with the row over, %0d failures",
                 n_leaves, n_done, n_fail);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
